>>> src/cst_pkg.sv
// Shared types and constants for the connection slot table.
// Used by the slot store and the top level; depends on nothing else.
package cst_pkg;

	localparam logic [15:0] DEFAULT_MTU = 16'd23;

	typedef enum logic [2:0] {
		OP_CONNECT    = 3'd0,
		OP_DISCONNECT = 3'd1,
		OP_MTU_CHANGE = 3'd2,
		OP_LOOKUP     = 3'd3,
		OP_QUERY      = 3'd4
	} op_t;

	typedef struct packed {
		logic set_valid;
		logic clr_valid;
		logic wr_handle;
		logic wr_mtu;
	} wr_ctl_t;

endpackage

>>> src/cst_slot_store.sv
// Slot storage: valid marks, handles and MTUs with one read and one write port.
// Depends on cst_pkg for the write control struct.
module cst_slot_store #(
	parameter int MAX_SLOTS = 8,
	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_idx,
	output logic             rd_valid,
	output logic [15:0]      rd_handle,
	output logic [15:0]      rd_mtu,
	input  cst_pkg::wr_ctl_t wr_ctl,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [15:0]      wr_handle_data,
	input  logic [15:0]      wr_mtu_data
);
	import cst_pkg::*;

	logic [MAX_SLOTS-1:0] valid_q;
	logic [15:0]          handle_q [MAX_SLOTS];
	logic [15:0]          mtu_q    [MAX_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_ctl.set_valid) begin
			valid_q[wr_idx] <= 1'b1;
		end else if (wr_ctl.clr_valid) begin
			valid_q[wr_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ctl.wr_handle) begin
			handle_q[wr_idx] <= wr_handle_data;
		end
		if (wr_ctl.wr_mtu) begin
			mtu_q[wr_idx] <= wr_mtu_data;
		end
	end

	assign rd_valid  = valid_q[rd_idx];
	assign rd_handle = handle_q[rd_idx];
	assign rd_mtu    = mtu_q[rd_idx];

endmodule

>>> src/connection_slot_table.sv
// Connection slot table: maps link connection handles to client slots, one item at a time.
// Connect, disconnect, MTU change and lookup walk the slots one per cycle through one
// comparator and stop early on a match; a query reads the slot named by slot_index, and an
// unused code goes straight to the result. Input is ready again the cycle after the result
// is taken.
// Reset clears the valid marks and client count and sets max_clients to 8 (at most MAX_SLOTS).
module connection_slot_table #(
	parameter int MAX_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  max_clients,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [15:0] conn_handle,
	input  logic [15:0] new_mtu,
	input  logic [7:0]  slot_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [3:0]  slot_out,
	output logic        slot_valid,
	output logic [15:0] handle_out,
	output logic [15:0] mtu_out,
	output logic [3:0]  client_count
);
	import cst_pkg::*;

	localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SCAN_W = (IDX_W > 4) ? IDX_W : 4;
	localparam logic [3:0] MAX_SAT   = 4'((MAX_SLOTS > 15) ? 15 : MAX_SLOTS);
	localparam logic [3:0] MAX_RESET = 4'((MAX_SLOTS > 8) ? 8 : MAX_SLOTS);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_QUERY = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [3:0]        max_q;
	logic [3:0]        cnt_q, cnt_d;
	logic [SCAN_W-1:0] scan_q, scan_d;
	logic [SCAN_W-1:0] free_q, free_d;
	logic              free_seen_q, free_seen_d;

	logic [2:0]  op_q;
	logic [15:0] conn_handle_q;
	logic [15:0] new_mtu_q;
	logic [7:0]  slot_index_q;

	logic        found_q, found_d;
	logic [3:0]  slot_q, slot_d;
	logic        slot_valid_q, slot_valid_d;
	logic [15:0] handle_q, handle_d;
	logic [15:0] mtu_q, mtu_d;
	logic [3:0]  count_q, count_d;
	logic        load_res;

	logic [IDX_W-1:0] rd_idx;
	logic             rd_valid;
	logic [15:0]      rd_handle;
	logic [15:0]      rd_mtu;
	wr_ctl_t          wr_ctl;
	logic [IDX_W-1:0] wr_idx;
	logic [15:0]      wr_mtu_data;
	logic             scan_end;
	logic             hit;
	logic             accept;
	logic             in_range;

	cst_slot_store #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_idx        (rd_idx),
		.rd_valid      (rd_valid),
		.rd_handle     (rd_handle),
		.rd_mtu        (rd_mtu),
		.wr_ctl        (wr_ctl),
		.wr_idx        (wr_idx),
		.wr_handle_data(conn_handle_q),
		.wr_mtu_data   (wr_mtu_data)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == S_DONE);

	assign rd_idx   = (state_q == S_QUERY) ? slot_index_q[IDX_W-1:0] : scan_q[IDX_W-1:0];
	assign scan_end = (scan_q >= SCAN_W'(max_q));
	assign hit      = rd_valid && (rd_handle == conn_handle_q);
	assign in_range = (slot_index_q < {4'd0, max_q});

	always_comb begin
		state_d      = state_q;
		scan_d       = scan_q;
		free_d       = free_q;
		free_seen_d  = free_seen_q;
		cnt_d        = cnt_q;
		wr_ctl       = '0;
		wr_idx       = scan_q[IDX_W-1:0];
		wr_mtu_data  = new_mtu_q;
		load_res     = 1'b0;
		found_d      = 1'b0;
		slot_d       = max_q;
		slot_valid_d = 1'b0;
		handle_d     = '0;
		mtu_d        = '0;
		count_d      = cnt_q;

		unique case (state_q)
			S_IDLE: begin
				scan_d      = '0;
				free_seen_d = 1'b0;
				if (accept) begin
					unique case (op) inside
						OP_CONNECT, OP_DISCONNECT, OP_MTU_CHANGE, OP_LOOKUP: begin
							state_d = S_SCAN;
						end
						OP_QUERY: begin
							state_d = S_QUERY;
						end
						default: begin
							load_res = 1'b1;
							state_d  = S_DONE;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					load_res = 1'b1;
					state_d  = S_DONE;
					if (op_q == OP_CONNECT && free_seen_q) begin
						wr_idx      = free_q[IDX_W-1:0];
						wr_mtu_data = DEFAULT_MTU;
						wr_ctl      = '{set_valid: 1'b1, clr_valid: 1'b0,
							wr_handle: 1'b1, wr_mtu: 1'b1};
						cnt_d       = cnt_q + 4'd1;
						found_d     = 1'b1;
						slot_d      = 4'(free_q);
					end
				end else if (hit) begin
					load_res = 1'b1;
					state_d  = S_DONE;
					found_d  = 1'b1;
					slot_d   = 4'(scan_q);
					case (op_q)
						OP_DISCONNECT: begin
							wr_ctl.clr_valid = 1'b1;
							if (cnt_q != 4'd0) begin
								cnt_d = cnt_q - 4'd1;
							end
						end
						OP_MTU_CHANGE: begin
							wr_ctl.wr_mtu = 1'b1;
						end
						default: begin
						end
					endcase
				end else begin
					if (!rd_valid && !free_seen_q) begin
						free_seen_d = 1'b1;
						free_d      = scan_q;
					end
					scan_d = scan_q + SCAN_W'(1);
				end
				count_d = cnt_d;
			end
			S_QUERY: begin
				load_res = 1'b1;
				state_d  = S_DONE;
				if (in_range) begin
					found_d      = 1'b1;
					slot_d       = slot_index_q[3:0];
					slot_valid_d = rd_valid;
					handle_d     = rd_handle;
					mtu_d        = rd_mtu;
				end else begin
					mtu_d = DEFAULT_MTU;
				end
			end
			S_DONE: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			max_q       <= MAX_RESET;
			cnt_q       <= '0;
			scan_q      <= '0;
			free_q      <= '0;
			free_seen_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			scan_q      <= scan_d;
			free_q      <= free_d;
			free_seen_q <= free_seen_d;
			if (cfg_valid) begin
				max_q <= ({28'd0, max_clients} > MAX_SLOTS) ? MAX_SAT : max_clients;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q          <= op;
			conn_handle_q <= conn_handle;
			new_mtu_q     <= new_mtu;
			slot_index_q  <= slot_index;
		end
		if (load_res) begin
			found_q      <= found_d;
			slot_q       <= slot_d;
			slot_valid_q <= slot_valid_d;
			handle_q     <= handle_d;
			mtu_q        <= mtu_d;
			count_q      <= count_d;
		end
	end

	assign found        = found_q;
	assign slot_out     = slot_q;
	assign slot_valid   = slot_valid_q;
	assign handle_out   = handle_q;
	assign mtu_out      = mtu_q;
	assign client_count = count_q;

endmodule
